// File: hw/rtl/bbr_pkg.sv
// Shared constants and types for the BBR pacing and mode control block.
// No dependencies; the top level imports this package.
package bbr_pkg;

  localparam int PROBE_PHASES = 6;
  localparam int PHASE_W      = (PROBE_PHASES > 2) ? $clog2(PROBE_PHASES) : 1;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PROBE_PHASES - 1);

  localparam int GAIN_W = 18;
  localparam logic [GAIN_W-1:0] GAIN_HIGH = 18'd183501;  // 2.8 in Q16
  localparam logic [GAIN_W-1:0] GAIN_LOW  = 18'd23406;   // 1/2.8 in Q16
  localparam logic [GAIN_W-1:0] GAIN_DOWN = 18'd49152;   // 0.75
  localparam logic [GAIN_W-1:0] GAIN_ONE  = 18'd65536;   // 1.0
  localparam logic [GAIN_W-1:0] GAIN_UP   = 18'd81920;   // 1.25
  localparam logic [GAIN_W-1:0] GAIN_TWO  = 18'd131072;  // 2.0

  localparam logic [31:0] WIN_MIN = 32'd10;
  localparam logic [32:0] ROUND_LAG = 33'd3;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_DRAIN = 2'd1;
  localparam logic [1:0] MODE_PROBE = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PROD = 8'b0000_0010,
    S_MODE = 8'b0000_0100,
    S_RATE = 8'b0000_1000,
    S_WLO  = 8'b0001_0000,
    S_WHI  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } seq_state_t;

endpackage

// File: hw/rtl/bbr_ifs.sv
// Valid/ready channel interfaces for the measurement item and the result item.
// Depends on nothing; used by the top level ports.
interface bbr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] min_rtt;
  logic [31:0] max_bandwidth;
  logic [31:0] round_count;
  logic [31:0] unacked;
  logic [47:0] now_time;
  logic [2:0]  start_phase;

  modport source (output valid, min_rtt, max_bandwidth, round_count, unacked,
                  now_time, start_phase, input ready);
  modport sink   (input valid, min_rtt, max_bandwidth, round_count, unacked,
                  now_time, start_phase, output ready);
endinterface

interface bbr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  probe_phase_out;
  logic [33:0] pacing_rate;
  logic [31:0] window_packets;

  modport source (output valid, mode, probe_phase_out, pacing_rate, window_packets,
                  input ready);
  modport sink   (input valid, mode, probe_phase_out, pacing_rate, window_packets,
                  output ready);
endinterface

// File: hw/rtl/bbr_mul.sv
// Shared 32x32 multiplier with a registered 64-bit product.
// Does not import bbr_pkg; no package items needed.
module bbr_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end

  assign p = p_r;

endmodule

// File: hw/rtl/bbr_pacing_mode_control_top.sv
// BBR pacing and mode control: one step of simplified BBR per measurement item.
// Depends on bbr_pkg, bbr_ifs (channel interfaces) and bbr_mul.
//
// Each accepted item updates the bandwidth peak, the mode (start, drain, probe
// bandwidth) and the probe phase, then yields one result item with the mode,
// the phase, the pacing rate (bandwidth times a Q16 gain) and the congestion
// window (bandwidth times RTT times a Q16 gain, plus one, at least 10,
// saturating at 32 bits). All products go through a single registered 32x32
// multiplier that a one-hot sequencer uses four times per item: bw*rtt, the
// pacing product, then the low and high halves of the 64-bit window product.
// The result item is valid once the sequencer has passed through S_PROD, S_MODE,
// S_RATE, S_WLO, S_WHI and S_FIN, and waits in its output register until taken;
// the input side is ready again the cycle after that, so a new item is accepted
// only after the last result is taken. Synchronous active-low reset returns
// the block to start mode with a zero peak, zero phase and zero phase time.
module bbr_pacing_mode_control_top
  import bbr_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  bbr_in_if.sink         in_ch,
  bbr_out_if.source      out_ch
);

  // Sequencer and model state
  seq_state_t         state_r, state_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [31:0]        peak_bw_r, peak_bw_nxt;
  logic [31:0]        peak_round_r, peak_round_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [47:0]        phase_start_r, phase_start_nxt;

  // Latched item fields
  logic [31:0] rtt_r, rtt_nxt;
  logic [31:0] bw_r, bw_nxt;
  logic [31:0] rnd_r, rnd_nxt;
  logic [31:0] flight_r, flight_nxt;
  logic [47:0] now_r, now_nxt;
  logic [2:0]  sp_r, sp_nxt;

  // Intermediate products and results
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] lop_r, lop_nxt;
  logic [33:0] rate_r, rate_nxt;
  logic [31:0] win_r, win_nxt;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  bbr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Decision logic
  logic               peak_hit;
  logic               round_hit;
  logic               flight_low;
  logic               enter_probe;
  logic               expired;
  logic [1:0]         mode_a;
  logic [1:0]         mode_b;
  logic [PHASE_W-1:0] sp_clamp;
  logic [PHASE_W-1:0] phase_a;
  logic [GAIN_W-1:0]  rate_gain;
  logic [GAIN_W-1:0]  win_gain;
  logic [50:0]        win_sum;
  logic [38:0]        win_q;
  logic [31:0]        win_calc;

  // New peak when bw exceeds 1.25 times the old peak: bw*4 > peak*5
  assign peak_hit  = ({1'b0, bw_r, 2'b00}) > (35'(peak_bw_r) + {1'b0, peak_bw_r, 2'b00});
  // More than three rounds since the last peak, without wrap
  assign round_hit = (33'(peak_round_r) + ROUND_LAG) < 33'(rnd_r);
  // In-flight below bw*rtt / 2^28; the product is on the multiplier output in S_MODE
  assign flight_low = {4'b0000, flight_r, 28'd0} < mul_p;

  assign sp_clamp = (32'(sp_r) >= PROBE_PHASES) ? PHASE_LAST : PHASE_W'(sp_r);

  assign mode_a      = ((mode_r == MODE_START) && round_hit) ? MODE_DRAIN : mode_r;
  assign enter_probe = (mode_a == MODE_DRAIN) && flight_low;
  assign mode_b      = enter_probe ? MODE_PROBE : mode_a;
  assign phase_a     = enter_probe ? sp_clamp : phase_r;
  // On entry the phase time restarts at now, so only a zero RTT expires it
  assign expired     = enter_probe ? (rtt_r == 32'd0)
                                   : ((49'(phase_start_r) + 49'(rtt_r)) <= 49'(now_r));

  always_comb begin
    case (mode_r)
      MODE_START: rate_gain = GAIN_HIGH;
      MODE_DRAIN: rate_gain = GAIN_LOW;
      default: begin
        if (phase_r == '0) begin
          rate_gain = GAIN_DOWN;
        end else if (phase_r == PHASE_LAST) begin
          rate_gain = GAIN_UP;
        end else begin
          rate_gain = GAIN_ONE;
        end
      end
    endcase
  end

  assign win_gain = (mode_r == MODE_PROBE) ? GAIN_TWO : GAIN_HIGH;

  // Window: floor(prod*gain / 2^44) from the two half products, plus one
  assign win_sum = 51'(mul_p[49:0]) + 51'(lop_r[63:32]);
  assign win_q   = win_sum[50:12];

  always_comb begin
    if (win_q >= 39'h00FFFF_FFFF) begin
      win_calc = 32'hFFFF_FFFF;
    end else if ((win_q[31:0] + 32'd1) < WIN_MIN) begin
      win_calc = WIN_MIN;
    end else begin
      win_calc = win_q[31:0] + 32'd1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    peak_bw_nxt     = peak_bw_r;
    peak_round_nxt  = peak_round_r;
    phase_nxt       = phase_r;
    phase_start_nxt = phase_start_r;
    rtt_nxt         = rtt_r;
    bw_nxt          = bw_r;
    rnd_nxt         = rnd_r;
    flight_nxt      = flight_r;
    now_nxt         = now_r;
    sp_nxt          = sp_r;
    prod_nxt        = prod_r;
    lop_nxt         = lop_r;
    rate_nxt        = rate_r;
    win_nxt         = win_r;
    mul_a           = bw_r;
    mul_b           = rtt_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          rtt_nxt    = in_ch.min_rtt;
          bw_nxt     = in_ch.max_bandwidth;
          rnd_nxt    = in_ch.round_count;
          flight_nxt = in_ch.unacked;
          now_nxt    = in_ch.now_time;
          sp_nxt     = in_ch.start_phase;
          state_nxt  = S_PROD;
        end
      end
      S_PROD: begin
        // bw*rtt on the multiplier; take a new peak meanwhile
        if (peak_hit) begin
          peak_bw_nxt    = bw_r;
          peak_round_nxt = rnd_r;
        end
        state_nxt = S_MODE;
      end
      S_MODE: begin
        prod_nxt = mul_p;
        mode_nxt = mode_b;
        if ((mode_b == MODE_PROBE) && expired) begin
          phase_nxt       = (phase_a == PHASE_LAST) ? '0 : phase_a + PHASE_W'(1);
          phase_start_nxt = now_r;
        end else begin
          phase_nxt       = phase_a;
          phase_start_nxt = enter_probe ? now_r : phase_start_r;
        end
        state_nxt = S_RATE;
      end
      S_RATE: begin
        mul_b     = 32'(rate_gain);
        state_nxt = S_WLO;
      end
      S_WLO: begin
        rate_nxt  = mul_p[49:16];
        mul_a     = prod_r[31:0];
        mul_b     = 32'(win_gain);
        state_nxt = S_WHI;
      end
      S_WHI: begin
        lop_nxt   = mul_p;
        mul_a     = prod_r[63:32];
        mul_b     = 32'(win_gain);
        state_nxt = S_FIN;
      end
      S_FIN: begin
        win_nxt   = win_calc;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Hold the result item until the sink takes it
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      mode_r        <= MODE_START;
      peak_bw_r     <= '0;
      peak_round_r  <= '0;
      phase_r       <= '0;
      phase_start_r <= '0;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      peak_bw_r     <= peak_bw_nxt;
      peak_round_r  <= peak_round_nxt;
      phase_r       <= phase_nxt;
      phase_start_r <= phase_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rtt_r    <= rtt_nxt;
    bw_r     <= bw_nxt;
    rnd_r    <= rnd_nxt;
    flight_r <= flight_nxt;
    now_r    <= now_nxt;
    sp_r     <= sp_nxt;
    prod_r   <= prod_nxt;
    lop_r    <= lop_nxt;
    rate_r   <= rate_nxt;
    win_r    <= win_nxt;
  end

  // Channel outputs
  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = (state_r == S_OUT);
  assign out_ch.mode            = mode_r;
  assign out_ch.probe_phase_out = 3'(phase_r);
  assign out_ch.pacing_rate     = rate_r;
  assign out_ch.window_packets  = win_r;

endmodule
